/* hw/rtl/spbc_pkg.sv */
// Shared constants, types and helpers for the shadow poison bitmap checker.
`default_nettype none

package spbc_pkg;

    localparam int unsigned WINDOW_BYTES = 65536;
    localparam int unsigned SHADOW_DEPTH = (WINDOW_BYTES + 7) / 8;
    localparam int unsigned OFF_W        = $clog2(WINDOW_BYTES);
    localparam int unsigned IDX_W        = OFF_W - 3;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned SEL_W   = PADDR_W - 2;

    localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
    localparam logic [OP_W-1:0] OP_POISON = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [SEL_W-1:0] REG_WINDOW_BASE = 1'b0;

    localparam logic [2:0] SUB_FIRST = 3'd0;
    localparam logic [2:0] SUB_LAST  = 3'd7;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_WALK,
        S_LAST
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [7:0]       wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    // Bits lo_b..hi_b of one shadow byte set.
    function automatic logic [7:0] spbc_mask(input logic [2:0] lo_b, input logic [2:0] hi_b);
        logic [7:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            m[b] = (3'(b) >= lo_b) && (3'(b) <= hi_b);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/spbc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module spbc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/spbc_cfg.sv */
// APB register file holding the window base address.
`default_nettype none

module spbc_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [spbc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [spbc_pkg::PDATA_W-1:0]   pwdata,
    output      logic [spbc_pkg::PDATA_W-1:0]   prdata,
    output      logic                           pready,
    output      logic [spbc_pkg::ADDR_W-1:0]    o_window_base
);
    import spbc_pkg::*;

    logic [ADDR_W-1:0] r_base;
    logic [SEL_W-1:0]  reg_sel;
    logic              wr_en;

    assign reg_sel = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready && (reg_sel == REG_WINDOW_BASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (wr_en) begin
            r_base <= pwdata[ADDR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel == REG_WINDOW_BASE) begin
            prdata = PDATA_W'(r_base);
        end
    end

    assign o_window_base = r_base;

endmodule

`default_nettype wire

/* hw/rtl/spbc_ctrl.sv */
// Sequencer: range set-up, shadow byte walk (RMW on poison/clear), clearing pass.
`default_nettype none

module spbc_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output      logic                          o_busy,
    input  wire logic [spbc_pkg::OP_W-1:0]     i_operation,
    input  wire logic [spbc_pkg::ADDR_W-1:0]   i_address,
    input  wire logic [spbc_pkg::LEN_W-1:0]    i_length,
    input  wire logic                          i_is_write,
    input  wire logic [spbc_pkg::ADDR_W-1:0]   i_window_base,
    output      spbc_pkg::t_mem_req            o_mem_req,
    input  wire logic [7:0]                    i_mem_rdata,
    output      logic                          o_done,
    output      logic                          o_violation,
    output      logic                          o_out_of_window,
    output      logic                          o_access_was_write
);
    import spbc_pkg::*;

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_rd_vld;
    logic             r_done;

    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_off;
    logic [LEN_W-1:0]  r_lenm1;
    logic              r_len_zero;
    logic              r_wr;
    logic [OFF_W-1:0]  r_lo;
    logic [OFF_W-1:0]  r_hi;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_rd_first;
    logic              r_rd_last;
    logic              r_viol;
    logic              r_oow;

    logic              accept;
    logic              emit;
    logic [ADDR_W:0]   end_off;
    logic              in_win;
    logic [ADDR_W:0]   hi_src;
    logic              clip;
    logic [OFF_W-1:0]  prep_lo;
    logic [OFF_W-1:0]  prep_hi;
    logic              is_rng;
    logic              prep_walk;
    logic              prep_oow;
    logic [IDX_W-1:0]  lo_idx;
    logic [IDX_W-1:0]  hi_idx;
    logic [7:0]        mask;
    logic              hit;

    assign accept = i_start && !o_busy;
    assign lo_idx = r_lo[OFF_W-1:3];
    assign hi_idx = r_hi[OFF_W-1:3];

    // Range set-up: last offset, window test and clip to the window end.
    always_comb begin
        end_off   = {1'b0, r_off} + (ADDR_W+1)'(r_lenm1);
        in_win    = r_off < ADDR_W'(WINDOW_BYTES);
        // Outside the window only the part that wraps past the top can land in it.
        hi_src    = in_win ? end_off : {1'b0, end_off[ADDR_W-1:0]};
        clip      = hi_src >= (ADDR_W+1)'(WINDOW_BYTES);
        prep_hi   = clip ? OFF_W'(WINDOW_BYTES - 1) : hi_src[OFF_W-1:0];
        prep_lo   = in_win ? r_off[OFF_W-1:0] : '0;
        is_rng    = (r_op == OP_POISON) || (r_op == OP_CLEAR);
        prep_walk = !r_len_zero &&
                    (((r_op == OP_CHECK) && in_win) || (is_rng && (in_win || end_off[ADDR_W])));
        prep_oow  = ((r_op == OP_CHECK) || is_rng) && !in_win;
    end

    assign mask = spbc_mask(r_rd_first ? r_lo[2:0] : SUB_FIRST,
                            r_rd_last  ? r_hi[2:0] : SUB_LAST);
    assign hit  = |(i_mem_rdata & mask);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_idx == IDX_W'(SHADOW_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = prep_walk ? S_WALK : S_IDLE;
            end
            S_WALK: begin
                if (r_idx == hi_idx) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Walk index
    always_comb begin
        case (r_state)
            S_CLEAR: n_idx = r_idx + 1'b1;
            S_PREP:  n_idx = prep_lo[OFF_W-1:3];
            S_WALK:  n_idx = r_idx + 1'b1;
            default: n_idx = r_idx;
        endcase
    end

    // Outputs and memory request
    always_comb begin
        o_busy          = (r_state != S_IDLE);
        emit            = ((r_state == S_PREP) && !prep_walk) || (r_state == S_LAST);
        o_mem_req.raddr = r_idx;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_rd_idx;
        o_mem_req.wdata = i_mem_rdata;
        case (r_state)
            S_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_idx;
                o_mem_req.wdata = '0;
            end
            default: begin
                o_mem_req.we    = r_rd_vld && is_rng;
                o_mem_req.wdata = (r_op == OP_POISON) ? (i_mem_rdata | mask)
                                                      : (i_mem_rdata & ~mask);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rd_vld <= (r_state == S_WALK);
            r_done   <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_operation;
            r_off      <= i_address - i_window_base;
            r_lenm1    <= i_length - 1'b1;
            r_len_zero <= (i_length == '0);
            r_wr       <= i_is_write;
        end
        if (r_state == S_PREP) begin
            r_lo   <= prep_lo;
            r_hi   <= prep_hi;
            r_oow  <= prep_oow;
            r_viol <= 1'b0;
        end else if (r_rd_vld && (r_op == OP_CHECK)) begin
            r_viol <= r_viol | hit;
        end
        if (r_state == S_WALK) begin
            r_rd_idx   <= r_idx;
            r_rd_first <= (r_idx == lo_idx);
            r_rd_last  <= (r_idx == hi_idx);
        end
    end

    assign o_done             = r_done;
    assign o_violation        = r_viol;
    assign o_out_of_window    = r_oow;
    assign o_access_was_write = r_wr;

endmodule

`default_nettype wire

/* hw/rtl/shadow_poison_bitmap_checker_unit.sv */
// Flow: an accepted transaction goes to range set-up (S_PREP); o_done is registered
// from there when no shadow byte is visited, else from S_LAST after the walk (S_WALK).
// Throughput: new work is taken when busy is low; the walk handles one shadow byte a
// cycle through the single read and single write port of the shadow RAM.
// Reset: synchronous, active low; then a clearing pass zeroes the bitmap
// with busy high. Results cannot be stalled by the receiver.
`default_nettype none

module shadow_poison_bitmap_checker_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic [spbc_pkg::OP_W-1:0]     i_operation,
    input  wire logic [spbc_pkg::ADDR_W-1:0]   i_address,
    input  wire logic [spbc_pkg::LEN_W-1:0]    i_length,
    input  wire logic                          i_is_write,
    output      logic                          o_done,
    output      logic                          o_violation,
    output      logic                          o_out_of_window,
    output      logic                          o_access_was_write,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [spbc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [spbc_pkg::PDATA_W-1:0]  pwdata,
    output      logic [spbc_pkg::PDATA_W-1:0]  prdata,
    output      logic                          pready
);
    import spbc_pkg::*;

    logic [ADDR_W-1:0] window_base;
    t_mem_req          mem_req;
    logic [7:0]        mem_rdata;

    spbc_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_window_base (window_base)
    );

    spbc_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .o_busy             (busy),
        .i_operation        (i_operation),
        .i_address          (i_address),
        .i_length           (i_length),
        .i_is_write         (i_is_write),
        .i_window_base      (window_base),
        .o_mem_req          (mem_req),
        .i_mem_rdata        (mem_rdata),
        .o_done             (o_done),
        .o_violation        (o_violation),
        .o_out_of_window    (o_out_of_window),
        .o_access_was_write (o_access_was_write)
    );

    spbc_ram #(
        .WIDTH (8),
        .DEPTH (SHADOW_DEPTH)
    ) u_shadow_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/spbc_checker.sv */
// Port-level checks for the shadow poison bitmap checker, bound to the top level.
`default_nettype none

module spbc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done,
    input wire logic o_violation,
    input wire logic o_out_of_window
);

    // An accepted transaction holds off further starts.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low after an accepted transaction");

    // No result can appear in the cycle after an accept.
    a_no_done_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_done)
        else $error("result strobe directly after accept");

    // One strobe per transaction: never two in a row.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // A violation is only reported for an access starting inside the window.
    a_viol_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_violation && o_out_of_window))
        else $error("violation flagged together with out_of_window");

endmodule

bind shadow_poison_bitmap_checker_unit spbc_checker u_spbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_violation     (o_violation),
    .o_out_of_window (o_out_of_window)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the shadow poison bitmap checker: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;
    import spbc_pkg::*;

    localparam logic [OP_W-1:0]    OP_UNUSED        = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_WINDOW_BASE = {REG_WINDOW_BASE, 2'b00};
    localparam int DIRECTED_N  = 25;
    localparam int PHASE_N     = 5;
    localparam int PHASE_ITEMS = 190;
    localparam int CALM_TAIL   = 150;

    typedef struct packed {
        logic viol;
        logic oow;
        logic wr;
    } t_verdict;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic              wr;
        logic              typed;
        logic              want_viol;
        logic              want_oow;
    } t_stim_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_operation = '0;
    logic [ADDR_W-1:0]   i_address   = '0;
    logic [LEN_W-1:0]    i_length    = '0;
    logic                i_is_write  = 1'b0;
    logic                o_done;
    logic                o_violation;
    logic                o_out_of_window;
    logic                o_access_was_write;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Shadow copy of the bitmap and the window register
    logic [7:0]          shadow_map [SHADOW_DEPTH];
    logic [ADDR_W-1:0]   model_window_base;
    t_verdict            pending_verdicts [$];

    int mismatch_count  = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int violations_seen = 0;
    int outside_seen    = 0;

    // Typed expectations only where obvious; the rest go through the predictor
    t_stim_row directed_rows [DIRECTED_N] = '{
        '{OP_CHECK,  32'h0000_0000, 16'd1,     1'b0, 1'b1, 1'b0, 1'b0},
        '{OP_CHECK,  32'hFFFF_FFFF, 16'hFFFF,  1'b1, 1'b1, 1'b0, 1'b1},
        '{OP_UNUSED, 32'h0000_0010, 16'd5,     1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF,  1'b0, 1'b1, 1'b0, 1'b0},
        '{OP_POISON, 32'h0000_0100, 16'd8,     1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_CHECK,  32'h0000_0104, 16'd1,     1'b0, 1'b1, 1'b1, 1'b0},
        '{OP_CHECK,  32'h0000_00FC, 16'd4,     1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK,  32'h0000_00FC, 16'd5,     1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK,  32'h0000_0100, 16'd0,     1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_CLEAR,  32'h0000_0100, 16'd0,     1'b0, 1'b1, 1'b0, 1'b0},
        '{OP_CHECK,  32'h0000_0107, 16'd1,     1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_POISON, 32'h0000_FFFC, 16'd16,    1'b0, 1'b1, 1'b0, 1'b0},
        '{OP_CHECK,  32'h0000_FFFF, 16'hFFFF,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK,  32'h0001_0000, 16'd1,     1'b0, 1'b1, 1'b0, 1'b1},
        '{OP_POISON, 32'hFFFF_FFF8, 16'd16,    1'b1, 1'b1, 1'b0, 1'b1},
        '{OP_CHECK,  32'h0000_0000, 16'd1,     1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CLEAR,  32'hFFFF_FFF0, 16'h0020,  1'b0, 1'b1, 1'b0, 1'b1},
        '{OP_CHECK,  32'h0000_0000, 16'd16,    1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CLEAR,  32'h0000_0100, 16'd4,     1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK,  32'h0000_0100, 16'd4,     1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK,  32'h0000_0100, 16'd5,     1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_POISON, 32'h0000_0000, 16'hFFFF,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK,  32'h0000_8000, 16'd1,     1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CLEAR,  32'h0000_0000, 16'hFFFF,  1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK,  32'h0000_FFFE, 16'd2,     1'b1, 1'b0, 1'b0, 1'b0}
    };

    shadow_poison_bitmap_checker_unit DUT (.*);

    always #6 i_clk = ~i_clk;

    initial begin
        #500_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Apply one transaction to the shadow copy and return the verdict it yields
    function automatic t_verdict shadow_access(input logic [OP_W-1:0] op,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [LEN_W-1:0] len,
                                               input logic wr);
        t_verdict          v;
        logic [ADDR_W-1:0] rel;
        logic [ADDR_W-1:0] off;
        v.viol = 1'b0;
        v.oow  = 1'b0;
        v.wr   = wr;
        rel    = addr - model_window_base;
        if (op == OP_CHECK) begin
            if (rel >= WINDOW_BYTES) begin
                v.oow = 1'b1;
            end else begin
                for (int i = 0; i < int'(len); i++) begin
                    off = rel + ADDR_W'(i);
                    // bytes past the window end are untracked
                    if (off >= WINDOW_BYTES) break;
                    if (shadow_map[off[OFF_W-1:3]][off[2:0]]) begin
                        v.viol = 1'b1;
                        break;
                    end
                end
            end
        end else if (op == OP_POISON || op == OP_CLEAR) begin
            v.oow = (rel >= WINDOW_BYTES);
            for (int i = 0; i < int'(len); i++) begin
                // wraps modulo 2^32, so a range may re-enter the window
                off = rel + ADDR_W'(i);
                if (off < WINDOW_BYTES) begin
                    shadow_map[off[OFF_W-1:3]][off[2:0]] = (op == OP_POISON);
                end
            end
        end
        return v;
    endfunction

    function automatic void check_field(input string what, input logic want, input logic got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, what, want, got);
        end
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [LEN_W-1:0] len, input logic wr,
                             input logic typed, input logic want_viol, input logic want_oow);
        t_verdict v;
        @(negedge i_clk);
        i_operation = op;
        i_address   = addr;
        i_length    = len;
        i_is_write  = wr;
        start       = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        v = shadow_access(op, addr, len, wr);
        if (typed) begin
            v.viol = want_viol;
            v.oow  = want_oow;
        end
        pending_verdicts.push_back(v);
        items_sent++;
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off until every outstanding transaction has reported and the unit is idle
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_verdicts.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic set_window_base(input logic [ADDR_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_WINDOW_BASE;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        model_window_base = value;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        // read back through the same port
        @(negedge i_clk);
        psel    = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== model_window_base) begin
            mismatch_count++;
            $display("%0t: window_base readback mismatch, expected %h, actual %h",
                     $time, model_window_base, prdata);
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_done === 1'b1) begin
            results_checked++;
            if (o_violation) violations_seen++;
            if (o_out_of_window) outside_seen++;
            if (pending_verdicts.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with none expected, actual viol %0b oow %0b wr %0b",
                         $time, o_violation, o_out_of_window, o_access_was_write);
            end else begin
                want = pending_verdicts.pop_front();
                check_field("violation", want.viol, o_violation);
                check_field("out_of_window", want.oow, o_out_of_window);
                check_field("access_was_write", want.wr, o_access_was_write);
            end
        end
    end

    initial begin
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [OP_W-1:0]   op;
        int                hot_off;
        int                r;
        int                done_items;
        foreach (shadow_map[k]) shadow_map[k] = '0;
        model_window_base = '0;
        done_items        = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // wait out the clearing pass
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        for (int k = 0; k < DIRECTED_N; k++) begin
            send_item(directed_rows[k].op, directed_rows[k].addr, directed_rows[k].len,
                      directed_rows[k].wr, directed_rows[k].typed,
                      directed_rows[k].want_viol, directed_rows[k].want_oow);
        end

        for (int p = 0; p < PHASE_N; p++) begin
            case (p)
                0: base = 32'hFFFF_C000;
                1: base = 32'hFFFF_FFFF;
                2: base = $urandom;
                3: base = 32'h0001_0000;
                default: base = 32'h0000_0000;
            endcase
            drain();
            set_window_base(base);
            hot_off = $urandom_range(0, WINDOW_BYTES - 512);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == PHASE_ITEMS / 2) drain();

                r = $urandom_range(0, 99);
                if (r < 45) op = OP_CHECK;
                else if (r < 72) op = OP_POISON;
                else if (r < 95) op = OP_CLEAR;
                else op = OP_UNUSED;

                // aim half the ranges at a small hot spot so checks meet poison
                r = $urandom_range(0, 99);
                if (r < 50) addr = base + ADDR_W'(hot_off) + ADDR_W'($urandom_range(0, 511));
                else if (r < 62) addr = base + ADDR_W'($urandom_range(0, WINDOW_BYTES - 1));
                else if (r < 74) addr = base + ADDR_W'(WINDOW_BYTES - $urandom_range(1, 64));
                else if (r < 82) addr = base + ADDR_W'($urandom_range(0, 63));
                else if (r < 88) addr = base - ADDR_W'($urandom_range(1, 64));
                else if (r < 94) addr = base + ADDR_W'(WINDOW_BYTES + $urandom_range(0, 63));
                else addr = $urandom;

                // keep long walks rare
                r = $urandom_range(0, 99);
                if (r < 85) len = LEN_W'($urandom_range(0, 24));
                else if (r < 97) len = LEN_W'($urandom_range(25, 600));
                else len = LEN_W'($urandom_range(0, 65535));

                send_item(op, addr, len, 1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0);
                done_items++;
                if (done_items < PHASE_N * PHASE_ITEMS - CALM_TAIL
                        && $urandom_range(0, 4) == 0) begin
                    idle_gap($urandom_range(1, 7));
                end
            end
        end

        drain();
        repeat (16) @(posedge i_clk);

        $display("Drove %0d transactions over %0d window bases; checked %0d results",
                 items_sent, PHASE_N + 1, results_checked);
        $display("Results flagged %0d violations and %0d starts outside the window",
                 violations_seen, outside_seen);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
